/* src/gtfw_pkg.sv */
// ============================================================================
// gtfw_pkg: glyph text frame buffer writer package
// Shared constants, command and status codes, and the sequencer state type.
// ============================================================================
`default_nettype none

package gtfw_pkg;

    // Default screen geometry and glyph set size
    localparam int DEF_SCREEN_WIDTH  = 128;
    localparam int DEF_SCREEN_HEIGHT = 64;
    localparam int DEF_GLYPH_COUNT   = 96;

    // Frame store: fixed 1024 bytes, addressed by a 10-bit index
    localparam int FRAME_DEPTH = 1024;
    localparam int FRAME_AW    = 10;

    // Glyph cell geometry
    localparam int CELL       = 8;
    localparam int FIRST_CODE = 32;

    // Stream payload widths
    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 24;

    // Command codes
    localparam logic [2:0] MODE_GLYPH_WR   = 3'd0;
    localparam logic [2:0] MODE_CLEAR      = 3'd1;
    localparam logic [2:0] MODE_SET_CURSOR = 3'd2;
    localparam logic [2:0] MODE_PUT_CHAR   = 3'd3;
    localparam logic [2:0] MODE_READ       = 3'd4;

    // Status codes
    localparam logic [1:0] STAT_DONE       = 2'd0;
    localparam logic [1:0] STAT_OFF_SCREEN = 2'd1;
    localparam logic [1:0] STAT_NO_GLYPHS  = 2'd2;
    localparam logic [1:0] STAT_NO_CODE    = 2'd3;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_GLYPH,
        ST_DRAW,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

/* src/glyph_text_framebuffer_writer.sv */
// ============================================================================
// glyph_text_framebuffer_writer
// Page-organized monochrome frame store with an 8x8 glyph text renderer.
// ============================================================================
// Sequence per item: glyph write, set cursor, read byte and unused modes go
//   straight to finish; put character fetches the glyph rows, writes the
//   frame bytes, then finishes; clear frame sweeps the store and finishes.
// Flow: one item at a time; the next transfer is taken in the cycle after
//   the finish cycle, while the previous result may still sit in the output
//   register. Put character is bound by the single frame write port.
// Reset: asynchronous, active low. After reset a clearing pass zeroes all
//   1024 bytes of the frame store with s_axis_tready low. The glyph store is
//   not cleared.
// ============================================================================
`default_nettype none

module glyph_text_framebuffer_writer
    import gtfw_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
    parameter int GLYPH_COUNT   = DEF_GLYPH_COUNT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // pos_x[6:0], pos_y[12:7], char_code[20:13], glyph_row[23:21],
    // glyph_bits[31:24], read_address[41:32], zero pad[47:42]
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // mode[2:0]
    input  wire logic [IN_USER_W-1:0]  s_axis_tuser,

    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // read_data[7:0], status[9:8], cursor_col[16:10], cursor_row[23:17]
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    // ------------------------------------------------------------------
    // Derived geometry
    // ------------------------------------------------------------------
    localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
    localparam int GLYPH_CW    = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
    localparam int GLYPH_AW    = GLYPH_CW + 3;
    localparam int GLYPH_DEPTH = GLYPH_COUNT * CELL;

    // ------------------------------------------------------------------
    // Input field unpack
    // ------------------------------------------------------------------
    logic [2:0]          in_mode;
    logic [6:0]          in_pos_x;
    logic [5:0]          in_pos_y;
    logic [7:0]          in_char_code;
    logic [2:0]          in_glyph_row;
    logic [7:0]          in_glyph_bits;
    logic [FRAME_AW-1:0] in_read_address;

    assign in_mode         = s_axis_tuser[2:0];
    assign in_pos_x        = s_axis_tdata[6:0];
    assign in_pos_y        = s_axis_tdata[12:7];
    assign in_char_code    = s_axis_tdata[20:13];
    assign in_glyph_row    = s_axis_tdata[23:21];
    assign in_glyph_bits   = s_axis_tdata[31:24];
    assign in_read_address = s_axis_tdata[41:32];

    logic s_accept;
    assign s_accept = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // State registers
    // ------------------------------------------------------------------
    state_t              state_reg, state_next;
    logic [FRAME_AW-1:0] clr_cnt_reg, clr_cnt_next;   // clearing sweep address
    logic [3:0]          step_reg, step_next;         // glyph read / draw step
    logic                loaded_reg, loaded_next;     // any glyph row written
    logic [6:0]          col_reg, col_next;           // text cursor
    logic [6:0]          row_reg, row_next;
    logic [GLYPH_CW-1:0] code_off_reg, code_off_next; // glyph being drawn
    logic [1:0]          status_reg, status_next;
    logic                is_read_reg, is_read_next;
    logic                m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    // Glyph cell rows; row 0 ends in entry 0, current column in bit 7
    logic [7:0] rows_reg [CELL];

    // ------------------------------------------------------------------
    // Memories and their ports
    // ------------------------------------------------------------------
    logic [7:0] frame_mem [FRAME_DEPTH];
    logic [7:0] glyph_mem [GLYPH_DEPTH];

    logic                frame_we;
    logic [FRAME_AW-1:0] frame_waddr;
    logic [7:0]          frame_wdata;
    logic                frame_re;
    logic [7:0]          frame_rdata_reg;

    logic                glyph_we;
    logic [GLYPH_AW-1:0] glyph_waddr;
    logic                glyph_re;
    logic [GLYPH_AW-1:0] glyph_raddr;
    logic [7:0]          glyph_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (frame_we)
        begin
            frame_mem[frame_waddr] <= frame_wdata;
        end
        if (frame_re)
        begin
            frame_rdata_reg <= frame_mem[in_read_address];
        end
    end

    always_ff @(posedge clk)
    begin
        if (glyph_we)
        begin
            glyph_mem[glyph_waddr] <= in_glyph_bits;
        end
        if (glyph_re)
        begin
            glyph_rdata_reg <= glyph_mem[glyph_raddr];
        end
    end

    // ------------------------------------------------------------------
    // Decode helpers
    // ------------------------------------------------------------------
    logic [7:0] code_off8;
    logic       code_ok;
    logic       cursor_off;

    assign code_off8  = in_char_code - 8'(FIRST_CODE);
    assign code_ok    = (in_char_code >= 8'(FIRST_CODE)) &&
                        (code_off8 < 8'(GLYPH_COUNT));
    assign cursor_off = ({1'b0, col_reg} >= 8'(SCREEN_WIDTH)) ||
                        (row_reg >= 7'(SCREEN_HEIGHT));

    // ------------------------------------------------------------------
    // Draw datapath: step[3:1] is the cell column, step[0] picks the page
    // (upper page first, lower page only when the cell straddles two).
    // ------------------------------------------------------------------
    logic        draw_half;
    logic [2:0]  draw_c;
    logic [2:0]  row_off;
    logic [7:0]  col_bits;
    logic [15:0] col_shift;
    logic [7:0]  draw_col;
    logic [3:0]  draw_page;
    logic        draw_we;
    logic [FRAME_AW-1:0] draw_addr;
    logic [7:0]  draw_data;

    assign draw_half = step_reg[0];
    assign draw_c    = step_reg[3:1];
    assign row_off   = row_reg[2:0];

    always_comb
    begin
        for (int r = 0; r < CELL; r++)
        begin
            col_bits[r] = rows_reg[r][7];
        end
    end

    assign col_shift = {8'h00, col_bits} << row_off;
    assign draw_data = draw_half ? col_shift[15:8] : col_shift[7:0];
    assign draw_col  = {1'b0, col_reg} + {5'b0, draw_c};
    assign draw_page = {1'b0, row_reg[5:3]} + {3'b0, draw_half};
    assign draw_we   = (draw_col < 8'(SCREEN_WIDTH)) &&
                       (draw_page < 4'(PAGE_COUNT)) &&
                       (!draw_half || (row_off != 3'd0));
    assign draw_addr = FRAME_AW'(draw_page) * FRAME_AW'(SCREEN_WIDTH) +
                       FRAME_AW'(draw_col);

    // Cursor advance after a draw
    logic [7:0] col_plus;
    assign col_plus = {1'b0, col_reg} + 8'(CELL);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (clr_cnt_reg == FRAME_AW'(FRAME_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    if (in_mode == MODE_CLEAR)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else if (in_mode == MODE_PUT_CHAR && loaded_reg &&
                             !cursor_off && code_ok)
                    begin
                        state_next = ST_GLYPH;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_CLEAR:
            begin
                if (clr_cnt_reg == FRAME_AW'(FRAME_DEPTH - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_GLYPH:
            begin
                if (step_reg == 4'd8)
                begin
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW:
            begin
                if (step_reg == 4'd15)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath, memory controls and output register
    // ------------------------------------------------------------------
    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        step_next     = step_reg;
        loaded_next   = loaded_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        code_off_next = code_off_reg;
        status_next   = status_reg;
        is_read_next  = is_read_reg;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;

        frame_we    = 1'b0;
        frame_waddr = clr_cnt_reg;
        frame_wdata = 8'h00;
        frame_re    = 1'b0;
        glyph_we    = 1'b0;
        glyph_waddr = {code_off8[GLYPH_CW-1:0], in_glyph_row};
        glyph_re    = 1'b0;
        glyph_raddr = {code_off_reg, step_reg[2:0]};

        case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                // one byte a cycle; counter wraps back to zero at the end
                frame_we     = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    status_next  = STAT_DONE;
                    is_read_next = 1'b0;
                    step_next    = 4'd0;
                    case (in_mode)
                        MODE_GLYPH_WR:
                        begin
                            if (code_ok)
                            begin
                                glyph_we    = 1'b1;
                                loaded_next = 1'b1;
                            end
                            else
                            begin
                                status_next = STAT_NO_CODE;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            clr_cnt_next = '0;
                        end
                        MODE_SET_CURSOR:
                        begin
                            col_next = in_pos_x;
                            row_next = {1'b0, in_pos_y};
                            if (({1'b0, in_pos_x} >= 8'(SCREEN_WIDTH)) ||
                                ({1'b0, in_pos_y} >= 7'(SCREEN_HEIGHT)))
                            begin
                                status_next = STAT_OFF_SCREEN;
                            end
                        end
                        MODE_PUT_CHAR:
                        begin
                            code_off_next = code_off8[GLYPH_CW-1:0];
                            if (!loaded_reg)
                            begin
                                status_next = STAT_NO_GLYPHS;
                            end
                            else if (cursor_off)
                            begin
                                status_next = STAT_OFF_SCREEN;
                            end
                            else if (!code_ok)
                            begin
                                status_next = STAT_NO_CODE;
                            end
                        end
                        MODE_READ:
                        begin
                            frame_re     = 1'b1;
                            is_read_next = 1'b1;
                        end
                        default:
                        begin
                            status_next = STAT_DONE;
                        end
                    endcase
                end
            end
            ST_GLYPH:
            begin
                // read row s at step s, then shift it in from glyph_rdata_reg
                glyph_re  = (step_reg[3] == 1'b0);
                step_next = (step_reg == 4'd8) ? 4'd0 : step_reg + 4'd1;
            end
            ST_DRAW:
            begin
                frame_we    = draw_we;
                frame_waddr = draw_addr;
                frame_wdata = draw_data;
                step_next   = step_reg + 4'd1;
                if (step_reg == 4'd15)
                begin
                    if (col_plus > 8'(SCREEN_WIDTH - CELL))
                    begin
                        col_next = 7'd0;
                        row_next = row_reg + 7'(CELL);
                    end
                    else
                    begin
                        col_next = col_plus[6:0];
                    end
                end
            end
            ST_FINISH:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {row_reg, col_reg, status_reg,
                                    is_read_reg ? frame_rdata_reg : 8'h00};
                end
            end
            default:
            begin
                frame_we = 1'b0;
            end
        endcase
    end

    // Glyph cell shift line: loads during row reads, shifts one column left
    // as each column's lower-page step ends, written or not.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_GLYPH && step_reg != 4'd0)
        begin
            for (int i = 0; i < CELL - 1; i++)
            begin
                rows_reg[i] <= rows_reg[i+1];
            end
            rows_reg[CELL-1] <= glyph_rdata_reg;
        end
        else if (state_reg == ST_DRAW && draw_half)
        begin
            for (int i = 0; i < CELL; i++)
            begin
                rows_reg[i] <= {rows_reg[i][6:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_INIT;
            clr_cnt_reg <= '0;
            step_reg    <= 4'd0;
            loaded_reg  <= 1'b0;
            col_reg     <= 7'd0;
            row_reg     <= 7'd0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            step_reg    <= step_next;
            loaded_reg  <= loaded_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_off_reg <= code_off_next;
        status_reg   <= status_next;
        is_read_reg  <= is_read_next;
        m_data_reg   <= m_data_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

`default_nettype wire

/* src/gtfw_checker.sv */
// ============================================================================
// gtfw_checker
// Port-level checks on the text frame buffer writer, bound to the top level.
// ============================================================================
`default_nettype none

module gtfw_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata
);

    // items taken but not yet delivered
    logic [1:0] pend_reg, pend_next;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        pend_next = pend_reg + {1'b0, in_xfer} - {1'b0, out_xfer};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 2'd0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !s_axis_tready)
        else $error("input taken while an item is in process");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> pend_reg != 2'd0)
        else $error("result without an item");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> pend_reg == 2'd0 || pend_reg == 2'd1)
        else $error("too many items in flight");

    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[9:8] != 2'd0 |-> m_axis_tdata[7:0] == 8'h00)
        else $error("read data set on a flagged result");

endmodule

bind glyph_text_framebuffer_writer gtfw_checker u_gtfw_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

/* bench/glyph_text_framebuffer_writer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_text_framebuffer_writer_tb: self-checking bench for the text writer
// Runs a short table of directed commands, then random glyph loads, text
// runs, frame clears and noise. Every reply transfer is checked field by field
// against the table or a local model of the frame store, glyph store and cursor.
// ----------------------------------------------------------------------------

module glyph_text_framebuffer_writer_tb;
    import gtfw_pkg::*;

    localparam int SCREEN_W   = DEF_SCREEN_WIDTH;
    localparam int SCREEN_H   = DEF_SCREEN_HEIGHT;
    localparam int GLYPHS     = DEF_GLYPH_COUNT;
    localparam int PAGE_COUNT = (SCREEN_H + 7) / 8;

    localparam int RANDOM_ITEMS = 1225;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int SETTLE       = 40;     // put character is the slowest short op

    // spare command codes, no effect on the block
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    localparam logic TYPED     = 1'b1;
    localparam logic PREDICTED = 1'b0;

    typedef struct packed {
        logic [2:0] mode;
        logic [6:0] pos_x;
        logic [5:0] pos_y;
        logic [7:0] char_code;
        logic [2:0] glyph_row;
        logic [7:0] glyph_bits;
        logic [9:0] read_address;
    } text_cmd_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] status;
        logic [6:0] cursor_col;
        logic [6:0] cursor_row;
    } writer_reply_t;

    typedef struct packed {
        text_cmd_t     cmd;
        logic          typed;
        writer_reply_t reply;
    } script_row_t;

    // Directed opening: empty frame, draws before any glyph, bad glyph codes,
    // a full glyph load, clipping at the right and bottom edges, line wrap,
    // spare modes and a frame clear.
    localparam int SCRIPT_ROWS = 28;
    localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
        '{'{MODE_READ,       0,  0,   0, 0, 8'h00,    0}, TYPED, '{0, STAT_DONE, 0, 0}},
        '{'{MODE_READ,       0,  0,   0, 0, 8'h00, 1023}, TYPED, '{0, STAT_DONE, 0, 0}},
        '{'{MODE_PUT_CHAR,   0,  0,  65, 0, 8'h00,    0}, TYPED, '{0, STAT_NO_GLYPHS, 0, 0}},
        '{'{MODE_GLYPH_WR,   0,  0,  31, 0, 8'hFF,    0}, TYPED, '{0, STAT_NO_CODE, 0, 0}},
        '{'{MODE_GLYPH_WR,   0,  0, 128, 7, 8'hFF,    0}, TYPED, '{0, STAT_NO_CODE, 0, 0}},
        '{'{MODE_PUT_CHAR,   0,  0,   0, 0, 8'h00,    0}, TYPED, '{0, STAT_NO_GLYPHS, 0, 0}},
        '{'{MODE_GLYPH_WR,   0,  0, 127, 0, 8'hFF,    0}, TYPED, '{0, STAT_DONE, 0, 0}},
        '{'{MODE_GLYPH_WR,   0,  0, 127, 1, 8'h81,    0}, TYPED, '{0, STAT_DONE, 0, 0}},
        '{'{MODE_GLYPH_WR,   0,  0, 127, 2, 8'h42,    0}, TYPED, '{0, STAT_DONE, 0, 0}},
        '{'{MODE_GLYPH_WR,   0,  0, 127, 3, 8'h24,    0}, TYPED, '{0, STAT_DONE, 0, 0}},
        '{'{MODE_GLYPH_WR,   0,  0, 127, 4, 8'h18,    0}, TYPED, '{0, STAT_DONE, 0, 0}},
        '{'{MODE_GLYPH_WR,   0,  0, 127, 5, 8'h00,    0}, TYPED, '{0, STAT_DONE, 0, 0}},
        '{'{MODE_GLYPH_WR,   0,  0, 127, 6, 8'hAA,    0}, TYPED, '{0, STAT_DONE, 0, 0}},
        '{'{MODE_GLYPH_WR,   0,  0, 127, 7, 8'h55,    0}, TYPED, '{0, STAT_DONE, 0, 0}},
        '{'{MODE_PUT_CHAR,   0,  0, 127, 0, 8'h00,    0}, PREDICTED, '0},
        '{'{MODE_READ,       0,  0,   0, 0, 8'h00,    0}, PREDICTED, '0},
        '{'{MODE_PUT_CHAR,   0,  0,  31, 0, 8'h00,    0}, TYPED, '{0, STAT_NO_CODE, 8, 0}},
        '{'{MODE_PUT_CHAR,   0,  0, 255, 0, 8'h00,    0}, TYPED, '{0, STAT_NO_CODE, 8, 0}},
        '{'{MODE_SET_CURSOR, 127, 63, 0, 0, 8'h00,    0}, TYPED, '{0, STAT_DONE, 127, 63}},
        '{'{MODE_PUT_CHAR,   0,  0, 127, 0, 8'h00,    0}, PREDICTED, '0},
        '{'{MODE_PUT_CHAR,   0,  0, 127, 0, 8'h00,    0}, TYPED, '{0, STAT_OFF_SCREEN, 0, 71}},
        '{'{MODE_SET_CURSOR, 120, 56, 0, 0, 8'h00,    0}, TYPED, '{0, STAT_DONE, 120, 56}},
        '{'{MODE_PUT_CHAR,   0,  0, 127, 0, 8'h00,    0}, PREDICTED, '0},
        '{'{MODE_READ,       0,  0,   0, 0, 8'h00, 1023}, PREDICTED, '0},
        '{'{MODE_SPARE_LO,   5,  9,  77, 3, 8'h3C,  512}, PREDICTED, '0},
        '{'{MODE_SPARE_HI, 127, 63, 255, 7, 8'hFF, 1023}, PREDICTED, '0},
        '{'{MODE_CLEAR,      0,  0,   0, 0, 8'h00,    0}, PREDICTED, '0},
        '{'{MODE_READ,       0,  0,   0, 0, 8'h00, 1023}, TYPED, '{0, STAT_DONE, 0, 64}}
    };

    logic clk;
    logic rst_n = 1'b0;

    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata  = '0;
    logic [IN_USER_W-1:0] s_axis_tuser  = '0;

    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // local copy of the block's state
    logic [7:0] frame_bytes [FRAME_DEPTH]     = '{default: 8'h00};
    logic [7:0] glyph_bytes [GLYPHS * CELL]   = '{default: 8'h00};
    logic [7:0] glyph_rows_set [GLYPHS]       = '{default: 8'h00};
    logic [7:0] full_codes [$];               // codes with all eight rows written
    logic       font_ready = 1'b0;
    int         cur_col    = 0;
    int         cur_row    = 0;
    int         last_cell  = 0;               // frame index of the latest drawn cell

    writer_reply_t reply_q [$];
    int  sent_count   = 0;
    int  replies_seen = 0;
    int  fault_count  = 0;
    int  cycle_count  = 0;
    bit  drain_first  = 1'b0;

    glyph_text_framebuffer_writer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic bit in_font(input logic [7:0] code);
        return code >= FIRST_CODE && code < FIRST_CODE + GLYPHS;
    endfunction

    // -1 for pixels right of the screen or below the last page
    function automatic int frame_index(input int y, input int x);
        if ((y >> 3) >= PAGE_COUNT || x >= SCREEN_W)
            return -1;
        return (y >> 3) * SCREEN_W + x;
    endfunction

    function automatic writer_reply_t apply_text_cmd(input text_cmd_t c);
        writer_reply_t r;
        int            gi;
        int            base;
        int            idx;
        logic [7:0]    bits;
        r = '0;
        case (c.mode)
            MODE_GLYPH_WR:
            begin
                if (in_font(c.char_code))
                begin
                    gi = (int'(c.char_code) - FIRST_CODE) * CELL + int'(c.glyph_row);
                    glyph_bytes[gi] = c.glyph_bits;
                    if (glyph_rows_set[gi / CELL] != 8'hFF)
                    begin
                        glyph_rows_set[gi / CELL][c.glyph_row] = 1'b1;
                        if (glyph_rows_set[gi / CELL] == 8'hFF)
                            full_codes.push_back(c.char_code);
                    end
                    font_ready = 1'b1;
                end
                else
                    r.status = STAT_NO_CODE;
            end
            MODE_CLEAR:
                foreach (frame_bytes[i])
                    frame_bytes[i] = 8'h00;
            MODE_SET_CURSOR:
            begin
                cur_col = int'(c.pos_x);
                cur_row = int'(c.pos_y);
                if (cur_col >= SCREEN_W || cur_row >= SCREEN_H)
                    r.status = STAT_OFF_SCREEN;
            end
            MODE_PUT_CHAR:
            begin
                if (!font_ready)
                    r.status = STAT_NO_GLYPHS;
                else if (cur_col >= SCREEN_W || cur_row >= SCREEN_H)
                    r.status = STAT_OFF_SCREEN;
                else if (!in_font(c.char_code))
                    r.status = STAT_NO_CODE;
                else
                begin
                    base = (int'(c.char_code) - FIRST_CODE) * CELL;
                    // whole page bytes under the cell are wiped before the OR
                    for (int dy = 0; dy < CELL; dy++)
                        for (int dx = 0; dx < CELL; dx++)
                        begin
                            idx = frame_index(cur_row + dy, cur_col + dx);
                            if (idx >= 0)
                                frame_bytes[idx] = 8'h00;
                        end
                    for (int dy = 0; dy < CELL; dy++)
                    begin
                        bits = glyph_bytes[base + dy];
                        for (int dx = 0; dx < CELL; dx++)
                        begin
                            idx = frame_index(cur_row + dy, cur_col + dx);
                            if (idx >= 0 && bits[7 - dx])
                                frame_bytes[idx][(cur_row + dy) % 8] = 1'b1;
                        end
                    end
                    last_cell = frame_index(cur_row, cur_col);
                    cur_col += CELL;
                    if (cur_col > SCREEN_W - CELL)
                    begin
                        cur_col = 0;
                        cur_row += CELL;
                    end
                    cur_col &= 127;
                    cur_row &= 127;
                end
            end
            MODE_READ:
                r.read_data = frame_bytes[c.read_address];
            default:
                ;
        endcase
        r.cursor_col = cur_col[6:0];
        r.cursor_row = cur_row[6:0];
        return r;
    endfunction

    // A draw reads all eight glyph rows, so a half-loaded glyph must never be
    // drawn; steer such a code to a fully loaded one, or out of the glyph range.
    function automatic logic [7:0] drawable_code(input logic [7:0] code);
        if (!font_ready || cur_col >= SCREEN_W || cur_row >= SCREEN_H || !in_font(code))
            return code;
        if (glyph_rows_set[code - FIRST_CODE] == 8'hFF)
            return code;
        if (full_codes.size() == 0)
            return 8'd0;
        return full_codes[$urandom_range(0, full_codes.size() - 1)];
    endfunction

    function automatic text_cmd_t make_cmd(input int mode, input int x, input int y,
                                           input int code, input int row, input int bits,
                                           input int addr);
        text_cmd_t c;
        c.mode         = mode[2:0];
        c.pos_x        = x[6:0];
        c.pos_y        = y[5:0];
        c.char_code    = code[7:0];
        c.glyph_row    = row[2:0];
        c.glyph_bits   = bits[7:0];
        c.read_address = addr[9:0];
        return c;
    endfunction

    // Entered and left at a falling edge. Valid stays high between back to back
    // transfers; it only drops when a gap or a drain comes first.
    task automatic send_cmd(input text_cmd_t c, input logic typed, input writer_reply_t fixed);
        int            gap;
        writer_reply_t r;
        gap = ((sent_count / 150) % 5 == 2) ? 0 : $urandom_range(0, 15);
        if (gap > 0 || drain_first)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
            while (drain_first && reply_q.size() != 0)
                @(negedge clk);
            repeat (gap) @(negedge clk);
            drain_first = 1'b0;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W - 42){1'b0}}, c.read_address, c.glyph_bits,
                          c.glyph_row, c.char_code, c.pos_y, c.pos_x};
        s_axis_tuser  <= c.mode;
        do
            @(posedge clk);
        while (!s_axis_tready);
        r = apply_text_cmd(c);
        reply_q.push_back(typed ? fixed : r);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fault_count++;
        end
    endtask

    // Stimulus
    initial
    begin : stimulus
        text_cmd_t c;
        int        pick;
        int        n;
        int        code;
        int        addr;
        bit        drained;
        drained = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // tready stays low through the clearing pass after reset
        @(negedge clk);

        for (int i = 0; i < SCRIPT_ROWS; i++)
            send_cmd(SCRIPT[i].cmd, SCRIPT[i].typed, SCRIPT[i].reply);

        while (sent_count < SCRIPT_ROWS + RANDOM_ITEMS)
        begin
            // once, mid run, hold the next item until the block has answered all
            if (!drained && sent_count >= 700)
            begin
                drain_first = 1'b1;
                drained     = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 12)
            begin
                // load one whole glyph
                code = FIRST_CODE + $urandom_range(0, GLYPHS - 1);
                for (int r = 0; r < CELL; r++)
                    send_cmd(make_cmd(MODE_GLYPH_WR, $urandom, $urandom, code, r,
                                      $urandom, $urandom), PREDICTED, '0);
            end
            else if (pick < 56)
            begin
                // text run: place the cursor, draw a few cells, read some back
                c = make_cmd(MODE_SET_CURSOR,
                             $urandom_range(0, 1) ? 8 * $urandom_range(0, 15)
                                                  : $urandom_range(0, 127),
                             $urandom_range(0, 1) ? 8 * $urandom_range(0, 7)
                                                  : $urandom_range(0, 63),
                             $urandom, $urandom, $urandom, $urandom);
                send_cmd(c, PREDICTED, '0);
                n = $urandom_range(3, 12);
                for (int k = 0; k < n; k++)
                begin
                    code = ($urandom_range(0, 99) < 85 && full_codes.size() > 0)
                         ? int'(full_codes[$urandom_range(0, full_codes.size() - 1)])
                         : $urandom_range(0, 255);
                    send_cmd(make_cmd(MODE_PUT_CHAR, $urandom, $urandom,
                                      drawable_code(code[7:0]), $urandom, $urandom,
                                      $urandom), PREDICTED, '0);
                end
                n = $urandom_range(1, 3);
                for (int k = 0; k < n; k++)
                begin
                    addr = ($urandom_range(0, 3) == 0)
                         ? $urandom_range(0, 1023)
                         : last_cell + SCREEN_W * $urandom_range(0, 1) + $urandom_range(0, 7);
                    send_cmd(make_cmd(MODE_READ, $urandom, $urandom, $urandom, $urandom,
                                      $urandom, addr), PREDICTED, '0);
                end
            end
            else if (pick < 60)
                send_cmd(make_cmd(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom,
                                  $urandom, $urandom), PREDICTED, '0);
            else
            begin
                // noise: any mode, any field values
                c = make_cmd($urandom_range(0, 7), $urandom_range(0, 127),
                             $urandom_range(0, 63), $urandom_range(0, 255),
                             $urandom_range(0, 7), $urandom_range(0, 255),
                             $urandom_range(0, 1023));
                if (c.mode == MODE_PUT_CHAR)
                    c.char_code = drawable_code(c.char_code);
                send_cmd(c, PREDICTED, '0);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (reply_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (fault_count == 0)
            $display("[glyph_text_framebuffer_writer] OK");
        else
            $display("[glyph_text_framebuffer_writer] ERROR");
        $finish;
    end

    // Reply side: random stalls, a window with none, and one long hold-off
    // that backs the block up into its input.
    initial
    begin : reply_sink
        int            wait_cycles;
        bit            long_hold_done;
        writer_reply_t want;
        writer_reply_t got;
        long_hold_done = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (!long_hold_done && replies_seen == 300)
            begin
                wait_cycles    = 400;
                long_hold_done = 1'b1;
            end
            else
                wait_cycles = ((replies_seen / 170) % 5 == 3) ? 0 : $urandom_range(0, 15);
            if (wait_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (wait_cycles) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            got.read_data  = m_axis_tdata[7:0];
            got.status     = m_axis_tdata[9:8];
            got.cursor_col = m_axis_tdata[16:10];
            got.cursor_row = m_axis_tdata[23:17];
            replies_seen++;
            if (reply_q.size() == 0)
            begin
                $error("reply transfer with nothing outstanding: %h", m_axis_tdata);
                fault_count++;
            end
            else
            begin
                want = reply_q.pop_front();
                check_field("read_data", want.read_data, got.read_data);
                check_field("status", 8'(want.status), 8'(got.status));
                check_field("cursor_col", 8'(want.cursor_col), 8'(got.cursor_col));
                check_field("cursor_row", 8'(want.cursor_row), 8'(got.cursor_row));
            end
            @(negedge clk);
        end
    end

    // Watchdog
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[glyph_text_framebuffer_writer] ERROR");
        $finish;
    end

endmodule

/* sim.f */
src/gtfw_pkg.sv
src/glyph_text_framebuffer_writer.sv
src/gtfw_checker.sv
bench/glyph_text_framebuffer_writer_tb.sv
